>>> hw/rtl/alsr_pkg.sv
// Shared types and constants of the SGR line restorer.
// Used by every module of the block; depends on nothing.
package alsr_pkg;

  localparam int unsigned MaxCodesDef   = 16;
  localparam int unsigned QueueDepthDef = 4;
  localparam int unsigned NumSlots      = 18;
  localparam int unsigned CntW          = 5;

  localparam logic [7:0] ChEsc  = 8'h1b;
  localparam logic [7:0] ChLb   = 8'h5b;
  localparam logic [7:0] ChSemi = 8'h3b;
  localparam logic [7:0] ChM    = 8'h6d;
  localparam logic [7:0] ChNl   = 8'h0a;
  localparam logic [7:0] Ch0    = 8'h30;
  localparam logic [7:0] Ch1    = 8'h31;
  localparam logic [7:0] Ch3    = 8'h33;
  localparam logic [7:0] Ch4    = 8'h34;
  localparam logic [7:0] Ch7    = 8'h37;
  localparam logic [7:0] Ch9    = 8'h39;

  localparam logic [7:0] CodeReset = 8'd0;
  localparam logic [7:0] CodeBold  = 8'd1;
  localparam logic [7:0] CodeFaint = 8'd2;
  localparam logic [7:0] CodeInv   = 8'd7;
  localparam logic [7:0] CodeNoInt = 8'd22;
  localparam logic [7:0] CodeNoInv = 8'd27;
  localparam logic [7:0] CodeFgLo  = 8'd30;
  localparam logic [7:0] CodeFgHi  = 8'd37;
  localparam logic [7:0] CodeNoFg  = 8'd39;
  localparam logic [7:0] CodeBgLo  = 8'd40;
  localparam logic [7:0] CodeBgHi  = 8'd47;
  localparam logic [7:0] CodeNoBg  = 8'd49;
  localparam logic [7:0] CodeFbLo  = 8'd90;
  localparam logic [7:0] CodeFbHi  = 8'd97;
  localparam logic [7:0] CodeBbLo  = 8'd100;
  localparam logic [7:0] CodeBbHi  = 8'd107;

  localparam logic [6:0] Dec30  = 7'd30;
  localparam logic [6:0] Dec40  = 7'd40;
  localparam logic [6:0] Dec90  = 7'd90;
  localparam logic [6:0] Dec100 = 7'd100;

  // output slot positions of one command
  localparam int unsigned SlotRelay   = 0;
  localparam int unsigned SlotRstEsc  = 1;
  localparam int unsigned SlotRstLb   = 2;
  localparam int unsigned SlotRst0    = 3;
  localparam int unsigned SlotRstM    = 4;
  localparam int unsigned SlotEsc     = 5;
  localparam int unsigned SlotLb      = 6;
  localparam int unsigned SlotInt     = 7;
  localparam int unsigned SlotInvSep  = 8;
  localparam int unsigned SlotInv     = 9;
  localparam int unsigned SlotFgSep   = 10;
  localparam int unsigned SlotFgTens  = 11;
  localparam int unsigned SlotFgOnes  = 12;
  localparam int unsigned SlotBgSep   = 13;
  localparam int unsigned SlotBgHund  = 14;
  localparam int unsigned SlotBgTens  = 15;
  localparam int unsigned SlotBgOnes  = 16;
  localparam int unsigned SlotFinal   = 17;

  typedef struct packed {
    logic [1:0] intensity;
    logic       inverse;
    logic [6:0] fore;
    logic [6:0] back;
  } attr_t;

  typedef struct packed {
    logic [7:0] data;
    logic       reset_req;
    logic       restore_req;
    attr_t      attr;
  } cmd_t;

endpackage

>>> hw/rtl/alsr_front.sv
// Front end: accepts input words, parses ESC [ ... m and tracks attributes.
// Emits one command per word into the queue; depends on alsr_pkg.
module alsr_front import alsr_pkg::*; #(
  parameter int unsigned MaxCodes = MaxCodesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] in_data_i,
  output logic       in_ready_o,
  input  logic       full_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  typedef enum logic [1:0] {
    ModeText,
    ModeEsc,
    ModeCsi
  } mode_e;

  mode_e            mode_q, mode_d;
  logic [7:0]       accum_q, accum_d;
  logic [CntW-1:0]  count_q, count_d;
  attr_t            attr_q, attr_d;
  logic             clear_q, clear_d;

  logic [7:0]  c;
  logic        is_digit, go_text, take, fin, restore;
  logic [11:0] mac;

  assign c          = in_data_i;
  assign is_digit   = (c >= Ch0) && (c <= Ch9);
  assign mac        = ({4'b0, accum_q} << 3) + ({4'b0, accum_q} << 1) + {8'b0, c[3:0]};
  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    mode_d  = mode_q;
    accum_d = accum_q;
    count_d = count_q;
    attr_d  = attr_q;
    clear_d = clear_q;
    go_text = 1'b0;
    take    = 1'b0;
    fin     = 1'b0;
    restore = 1'b0;

    case (mode_q)
      ModeEsc: begin
        if (c == ChLb) begin
          mode_d  = ModeCsi;
          count_d = '0;
          accum_d = '0;
          clear_d = 1'b0;
        end else begin
          go_text = 1'b1;
        end
      end
      ModeCsi: begin
        if (is_digit) begin
          accum_d = (mac > 12'd255) ? 8'd255 : mac[7:0];
        end else if (c == ChSemi) begin
          take = 1'b1;
        end else if (c == ChM) begin
          take   = 1'b1;
          fin    = 1'b1;
          mode_d = ModeText;
        end else begin
          go_text = 1'b1;
        end
      end
      default: begin
        go_text = 1'b1;
      end
    endcase

    if (take && (count_q < CntW'(MaxCodes))) begin
      count_d = count_q + 1'b1;
      accum_d = '0;
      if (accum_q == CodeReset) begin
        attr_d = '0;
      end else if (accum_q == CodeBold || accum_q == CodeFaint) begin
        attr_d.intensity = accum_q[1:0];
      end else if (accum_q == CodeNoInt) begin
        attr_d.intensity = '0;
        clear_d          = 1'b1;
      end else if (accum_q == CodeInv) begin
        attr_d.inverse = 1'b1;
      end else if (accum_q == CodeNoInv) begin
        attr_d.inverse = 1'b0;
        clear_d        = 1'b1;
      end else if ((accum_q >= CodeFgLo && accum_q <= CodeFgHi) ||
                   (accum_q >= CodeFbLo && accum_q <= CodeFbHi)) begin
        attr_d.fore = accum_q[6:0];
      end else if (accum_q == CodeNoFg) begin
        attr_d.fore = '0;
        clear_d     = 1'b1;
      end else if ((accum_q >= CodeBgLo && accum_q <= CodeBgHi) ||
                   (accum_q >= CodeBbLo && accum_q <= CodeBbHi)) begin
        attr_d.back = accum_q[6:0];
      end else if (accum_q == CodeNoBg) begin
        attr_d.back = '0;
        clear_d     = 1'b1;
      end
    end

    if (go_text) begin
      mode_d  = (c == ChEsc) ? ModeEsc : ModeText;
      restore = (c == ChNl);
    end
  end

  always_comb begin
    cmd_o.data        = c;
    cmd_o.reset_req   = fin && clear_d;
    cmd_o.restore_req = restore || (fin && clear_d);
    cmd_o.attr        = attr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeText;
      accum_q <= '0;
      count_q <= '0;
      attr_q  <= '0;
      clear_q <= 1'b0;
    end else if (push_o) begin
      mode_q  <= mode_d;
      accum_q <= accum_d;
      count_q <= count_d;
      attr_q  <= attr_d;
      clear_q <= clear_d;
    end
  end

endmodule

>>> hw/rtl/alsr_queue.sv
// Command queue between the front end and the output sequencer.
// Small register file with head read; depends on alsr_pkg.
module alsr_queue import alsr_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/alsr_back.sv
// Back end: expands each queued command into output words; uses alsr_pkg.
// Walks a fixed slot list into a registered output, one word a cycle unless stalled.
module alsr_back import alsr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  cmd_t       head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_data_o,
  output logic       out_last_o
);

  logic [NumSlots-1:0] done_q, en, rem, pick;
  logic [7:0]          bytes [NumSlots];
  logic [7:0]          sel;
  logic                valid_q, last_q, last, load, rs, any, fg_hi, bg_hi;
  logic [7:0]          data_q;
  logic [6:0]          fg_ones, bg_ones;
  attr_t               a;

  assign a     = head_i.attr;
  assign any   = (a.intensity != '0) || a.inverse || (a.fore != '0) || (a.back != '0);
  assign rs    = head_i.restore_req && any;
  assign fg_hi = (a.fore >= Dec90);
  assign bg_hi = (a.back >= Dec100);
  assign fg_ones = a.fore - (fg_hi ? Dec90 : Dec30);
  assign bg_ones = a.back - (bg_hi ? Dec100 : Dec40);

  always_comb begin
    en                = '0;
    en[SlotRelay]     = 1'b1;
    en[SlotRstEsc]    = head_i.reset_req;
    en[SlotRstLb]     = head_i.reset_req;
    en[SlotRst0]      = head_i.reset_req;
    en[SlotRstM]      = head_i.reset_req;
    en[SlotEsc]       = rs;
    en[SlotLb]        = rs;
    en[SlotInt]       = rs && (a.intensity != '0);
    en[SlotInvSep]    = rs && a.inverse && (a.intensity != '0);
    en[SlotInv]       = rs && a.inverse;
    en[SlotFgSep]     = rs && (a.fore != '0) && ((a.intensity != '0) || a.inverse);
    en[SlotFgTens]    = rs && (a.fore != '0);
    en[SlotFgOnes]    = rs && (a.fore != '0);
    en[SlotBgSep]     = rs && (a.back != '0) &&
                        ((a.intensity != '0) || a.inverse || (a.fore != '0));
    en[SlotBgHund]    = rs && bg_hi;
    en[SlotBgTens]    = rs && (a.back != '0);
    en[SlotBgOnes]    = rs && (a.back != '0);
    en[SlotFinal]     = rs;
  end

  always_comb begin
    bytes[SlotRelay]  = head_i.data;
    bytes[SlotRstEsc] = ChEsc;
    bytes[SlotRstLb]  = ChLb;
    bytes[SlotRst0]   = Ch0;
    bytes[SlotRstM]   = ChM;
    bytes[SlotEsc]    = ChEsc;
    bytes[SlotLb]     = ChLb;
    bytes[SlotInt]    = Ch0 | {6'b0, a.intensity};
    bytes[SlotInvSep] = ChSemi;
    bytes[SlotInv]    = Ch7;
    bytes[SlotFgSep]  = ChSemi;
    bytes[SlotFgTens] = fg_hi ? Ch9 : Ch3;
    bytes[SlotFgOnes] = Ch0 | {4'b0, fg_ones[3:0]};
    bytes[SlotBgSep]  = ChSemi;
    bytes[SlotBgHund] = Ch1;
    bytes[SlotBgTens] = bg_hi ? Ch0 : Ch4;
    bytes[SlotBgOnes] = Ch0 | {4'b0, bg_ones[3:0]};
    bytes[SlotFinal]  = ChM;
  end

  assign rem  = en & ~done_q;
  assign pick = rem & (~rem + 1'b1);
  assign last = (rem == pick);
  assign load = !empty_i && (!valid_q || out_ready_i);
  assign pop_o = load && last;

  always_comb begin
    sel = '0;
    for (int i = 0; i < NumSlots; i++) begin
      sel = sel | ({8{pick[i]}} & bytes[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      done_q  <= '0;
    end else if (load) begin
      valid_q <= 1'b1;
      done_q  <= last ? '0 : (done_q | pick);
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= sel;
      last_q <= last;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
  assign out_last_o  = last_q;

endmodule

>>> hw/rtl/ansi_sgr_line_restorer.sv
// Channel  Dir  Signals                     Words
// s_axis   in   tvalid tready tdata[7:0]    in_byte
// m_axis   out  tvalid tready tdata[7:0]    out_byte, tlast = last_of_run
//
// One input word a cycle enters while the command queue has room.
// An input word expands to one or more words from the output sequencer; a text
// byte other than a newline gives one. Output passes the queue and output register.
// Reset clears parser state, attributes, queue and output valid.
// Output stalls fill the queue, then drop s_axis_tready.
// Top level of the SGR line restorer; instantiates alsr_front, alsr_queue, alsr_back.
module ansi_sgr_line_restorer import alsr_pkg::*; #(
  parameter int unsigned MaxCodes   = MaxCodesDef,
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast
);

  cmd_t push_cmd, head;
  logic push, pop, full, empty;

  alsr_front #(
    .MaxCodes(MaxCodes)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_data_i  (s_axis_tdata),
    .in_ready_o (s_axis_tready),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  alsr_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  alsr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

>>> hw/rtl/alsr_checker.sv
// Port-level checks for the SGR line restorer, bound to the top level.
// Sees only the top-level ports; depends on alsr_pkg.
module alsr_checker import alsr_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  logic in_acc, out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("output valid during reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tlast))
    else $error("stalled output word changed");

  a_in_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> ##2 m_axis_tvalid)
    else $error("accepted input word produced no output");

  a_run_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !m_axis_tlast |=> m_axis_tvalid)
    else $error("gap inside an output run");

  a_esc_lb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !m_axis_tlast && (m_axis_tdata == ChEsc) |=> (m_axis_tdata == ChLb))
    else $error("inserted escape not followed by bracket");

endmodule

bind ansi_sgr_line_restorer alsr_checker u_alsr_checker (.*);

>>> dv/sgr_restore_checker.sv
// Predicts the output words of ansi_sgr_line_restorer from the input words it takes
// and compares them with the words that leave the block. Depends on alsr_pkg.
`timescale 1ns / 1ps

module sgr_restore_checker import alsr_pkg::*; #(
  parameter int unsigned MaxCodes = MaxCodesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [7:0]  m_axis_tdata_i,
  input  logic        m_axis_tlast_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef enum logic [1:0] {
    ModeText,
    ModeEsc,
    ModeCsi
  } csi_mode_e;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } out_word_t;

  csi_mode_e       mode;
  logic [7:0]      param;
  logic [CntW-1:0] codes_taken;
  attr_t           attrs;
  logic            cleared;
  int unsigned     mismatches;

  logic [7:0] word_run[$];
  out_word_t  expected_q[$];

  task automatic push_decimal(input int unsigned v);
    if (v >= 100) word_run.push_back(Ch0 + 8'((v / 100) % 10));
    if (v >= 10) word_run.push_back(Ch0 + 8'((v / 10) % 10));
    word_run.push_back(Ch0 + 8'(v % 10));
  endtask

  task automatic push_restore();
    logic more;
    more = 1'b0;
    if (attrs == '0) return;
    word_run.push_back(ChEsc);
    word_run.push_back(ChLb);
    if (attrs.intensity != 0) begin
      push_decimal(32'(attrs.intensity));
      more = 1'b1;
    end
    if (attrs.inverse) begin
      if (more) word_run.push_back(ChSemi);
      word_run.push_back(Ch7);
      more = 1'b1;
    end
    if (attrs.fore != 0) begin
      if (more) word_run.push_back(ChSemi);
      push_decimal(32'(attrs.fore));
      more = 1'b1;
    end
    if (attrs.back != 0) begin
      if (more) word_run.push_back(ChSemi);
      push_decimal(32'(attrs.back));
    end
    word_run.push_back(ChM);
  endtask

  task automatic apply_param(input logic [7:0] g);
    if (g == CodeReset) begin
      attrs = '0;
    end else if (g == CodeBold || g == CodeFaint) begin
      attrs.intensity = g[1:0];
    end else if (g == CodeNoInt) begin
      attrs.intensity = '0;
      cleared = 1'b1;
    end else if (g == CodeInv) begin
      attrs.inverse = 1'b1;
    end else if (g == CodeNoInv) begin
      attrs.inverse = 1'b0;
      cleared = 1'b1;
    end else if ((g >= CodeFgLo && g <= CodeFgHi) || (g >= CodeFbLo && g <= CodeFbHi)) begin
      attrs.fore = g[6:0];
    end else if (g == CodeNoFg) begin
      attrs.fore = '0;
      cleared = 1'b1;
    end else if ((g >= CodeBgLo && g <= CodeBgHi) || (g >= CodeBbLo && g <= CodeBbHi)) begin
      attrs.back = g[6:0];
    end else if (g == CodeNoBg) begin
      attrs.back = '0;
      cleared = 1'b1;
    end
  endtask

  // drop the parameter once the sequence has taken its quota of codes
  task automatic take_param();
    if (codes_taken < MaxCodes) begin
      apply_param(param);
      codes_taken = codes_taken + 1'b1;
      param = '0;
    end
  endtask

  task automatic follow_text(input logic [7:0] c);
    mode = ModeText;
    if (c == ChEsc) mode = ModeEsc;
    else if (c == ChNl) push_restore();
  endtask

  task automatic follow_word(input logic [7:0] c);
    int unsigned acc;
    word_run.delete();
    word_run.push_back(c);
    case (mode)
      ModeEsc: begin
        if (c == ChLb) begin
          mode = ModeCsi;
          codes_taken = '0;
          param = '0;
          cleared = 1'b0;
        end else begin
          follow_text(c);
        end
      end
      ModeCsi: begin
        if (c >= Ch0 && c <= Ch9) begin
          acc = 32'(param) * 10 + 32'(c - Ch0);
          param = (acc > 255) ? 8'd255 : acc[7:0];
        end else if (c == ChSemi) begin
          take_param();
        end else if (c == ChM) begin
          take_param();
          if (cleared) begin
            word_run.push_back(ChEsc);
            word_run.push_back(ChLb);
            word_run.push_back(Ch0);
            word_run.push_back(ChM);
            push_restore();
          end
          mode = ModeText;
        end else begin
          follow_text(c);
        end
      end
      default: follow_text(c);
    endcase
    foreach (word_run[i]) expected_q.push_back('{data: word_run[i],
                                               last: (i == word_run.size() - 1)});
  endtask

  task automatic check_word(input logic [7:0] data, input logic last);
    out_word_t exp_word;
    if (expected_q.size() == 0) begin
      $display("%0t: out word with none expected, got data %02h last %0b",
               $time, data, last);
      mismatches++;
      return;
    end
    exp_word = expected_q.pop_front();
    if (exp_word.data !== data || exp_word.last !== last) begin
      $display("%0t: out word mismatch, expected data %02h last %0b, got data %02h last %0b",
               $time, exp_word.data, exp_word.last, data, last);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode = ModeText;
      param = '0;
      codes_taken = '0;
      attrs = '0;
      cleared = 1'b0;
      mismatches = 0;
      expected_q.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) check_word(m_axis_tdata_i, m_axis_tlast_i);
      if (s_axis_tvalid_i && s_axis_tready_i) follow_word(s_axis_tdata_i);
      fail_count_o <= mismatches;
      pending_o <= expected_q.size();
    end
  end

endmodule

>>> dv/ansi_sgr_line_restorer_test.sv
// Stimulus and verdict for ansi_sgr_line_restorer: text, SGR sequences and noise
// under random stalls on both sides. Depends on alsr_pkg, ansi_sgr_line_restorer and sgr_restore_checker.
`timescale 1ns / 1ps

module ansi_sgr_line_restorer_test;
  import alsr_pkg::*;

  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 30;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned src_idle_pct = 18;
  int unsigned sink_idle_pct = 62;
  int unsigned words_sent = 0;
  int unsigned quiet_cycles = 0;
  logic        sink_hold = 1'b0;

  ansi_sgr_line_restorer i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast
  );

  sgr_restore_checker i_checker (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tlast_i  (m_axis_tlast),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic send_word(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
  endtask

  task automatic send_decimal(input int unsigned v);
    int unsigned d;
    d = 1;
    while (d * 10 <= v) d = d * 10;
    while (d > 0) begin
      send_word(Ch0 + 8'((v / d) % 10));
      d = d / 10;
    end
  endtask

  // leave a zero parameter empty now and then, pad with a leading zero now and then
  task automatic send_param(input int unsigned v);
    if (v == 0 && $urandom_range(3) == 0) return;
    if ($urandom_range(9) == 0) send_word(Ch0);
    send_decimal(v);
  endtask

  function automatic int unsigned pick_code();
    logic [7:0] clears[4];
    clears = '{CodeNoInt, CodeNoInv, CodeNoFg, CodeNoBg};
    case ($urandom_range(9))
      0: return 32'(CodeReset);
      1: return $urandom_range(CodeBold, CodeFaint);
      2: return 32'(CodeInv);
      3: return 32'(clears[2'($urandom_range(3))]);
      4: return $urandom_range(CodeFgLo, CodeFgHi);
      5: return $urandom_range(CodeFbLo, CodeFbHi);
      6: return $urandom_range(CodeBgLo, CodeBgHi);
      7: return $urandom_range(CodeBbLo, CodeBbHi);
      8: return $urandom_range(255);
      default: return $urandom_range(256, 99999);
    endcase
  endfunction

  function automatic logic [7:0] pick_breaker();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if ((b >= Ch0 && b <= Ch9) || b == ChSemi || b == ChM) b = ChNl;
    return b;
  endfunction

  task automatic send_burst();
    int unsigned n;
    int unsigned k;
    logic [7:0]  b;
    k = $urandom_range(19);
    if (k <= 8) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(MaxCodesDef - 2, MaxCodesDef + 4)
                                   : $urandom_range(1, 4);
      send_word(ChEsc);
      send_word(ChLb);
      for (int unsigned i = 0; i < n; i++) begin
        if (i > 0) send_word(ChSemi);
        send_param(pick_code());
      end
      send_word(ChM);
      if ($urandom_range(2) == 0) send_word(ChNl);
    end else if (k <= 12) begin
      n = $urandom_range(1, 6);
      repeat (n) send_word(8'($urandom_range(8'h20, 8'h7e)));
      if ($urandom_range(1) == 0) send_word(ChNl);
    end else if (k <= 14) begin
      send_word(ChNl);
    end else if (k <= 16) begin
      send_word(ChEsc);
      if ($urandom_range(1) == 0) begin
        b = 8'($urandom_range(255));
        send_word(b == ChLb ? ChNl : b);
      end else begin
        send_word(ChLb);
        send_param(pick_code());
        if ($urandom_range(1) == 0) begin
          send_word(ChSemi);
          send_param(pick_code());
        end
        send_word(pick_breaker());
      end
    end else begin
      send_word(8'($urandom_range(255)));
    end
  endtask

  task automatic send_bursts(input int unsigned count);
    int unsigned stop_at;
    stop_at = words_sent + count;
    while (words_sent < stop_at) send_burst();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // byte extremes and a bare newline with nothing set
    send_word(8'h00);
    send_word(8'hff);
    send_word(ChNl);
    // set every attribute, then restore all of them after the newline
    send_word(ChEsc);
    send_word(ChLb);
    send_word(CodeBold + Ch0);
    send_word(ChSemi);
    send_word(Ch7);
    send_word(ChSemi);
    send_decimal(32'(CodeFbHi));
    send_word(ChSemi);
    send_decimal(32'(CodeBbHi));
    send_word(ChM);
    send_word(ChNl);
    // clear the foreground and set it again: reset plus the longest restore
    send_word(ChEsc);
    send_word(ChLb);
    send_decimal(32'(CodeNoFg));
    send_word(ChSemi);
    send_decimal(32'(CodeFbHi));
    send_word(ChM);

    send_bursts(115);

    src_idle_pct = 62;
    sink_idle_pct = 18;
    send_bursts(115);

    src_idle_pct = 0;
    sink_idle_pct = 0;
    fork
      begin
        sink_hold <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        sink_hold <= 1'b0;
      end
    join_none
    send_bursts(120);
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/alsr_pkg.sv
hw/rtl/alsr_front.sv
hw/rtl/alsr_queue.sv
hw/rtl/alsr_back.sv
hw/rtl/ansi_sgr_line_restorer.sv
hw/rtl/alsr_checker.sv
dv/sgr_restore_checker.sv
dv/ansi_sgr_line_restorer_test.sv
